>>> rtl/ndg_pkg.sv
`default_nettype none

package ndg_pkg;

    localparam int NOTE_KINDS = 4;
    localparam int AMOUNT_W   = 23;
    localparam int LOAD_W     = 16;
    localparam int OUT_W      = 16;
    localparam int BAL_W      = 23;
    localparam int NOTE_W     = 6;
    localparam int WANT_W     = 21;
    localparam int RECIP_W    = 24;
    localparam int PROD_W     = AMOUNT_W + RECIP_W;
    localparam int IDX_W      = $clog2(NOTE_KINDS);

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_WITHDRAW = 1'b1;

    localparam logic STATUS_DONE       = 1'b0;
    localparam logic STATUS_IMPOSSIBLE = 1'b1;

    localparam logic [NOTE_W-1:0] NOTE_VALUE [NOTE_KINDS] = '{6'd5, 6'd10, 6'd20, 6'd50};

    localparam logic [RECIP_W-1:0] RECIP_5  = 24'd13421773;
    localparam logic [RECIP_W-1:0] RECIP_25 = 24'd10737419;

    localparam logic [1:0] PRE_SHIFT [NOTE_KINDS] = '{2'd0, 2'd1, 2'd2, 2'd1};
    localparam logic [RECIP_W-1:0] RECIP [NOTE_KINDS] = '{RECIP_5, RECIP_5, RECIP_5, RECIP_25};
    localparam logic [4:0] POST_SHIFT [NOTE_KINDS] = '{5'd26, 5'd26, 5'd26, 5'd28};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_TAKE,
        ST_COMMIT,
        ST_BAL,
        ST_FINISH
    } ndg_state_t;

    typedef struct packed {
        logic             accept;
        logic             div;
        logic             take;
        logic             commit;
        logic             bal;
        logic             publish;
        logic [IDX_W-1:0] idx;
    } ndg_cmd_t;

    typedef struct packed {
        logic out_free;
    } ndg_stat_t;

endpackage

`default_nettype wire

>>> rtl/ndg_ctrl.sv
`default_nettype none

module ndg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             command,
    input  wire ndg_pkg::ndg_stat_t stat,
    output logic                  in_stall,
    output ndg_pkg::ndg_cmd_t     cmd
);
    import ndg_pkg::*;

    ndg_state_t       state_reg;
    ndg_state_t       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next   = IDX_W'(NOTE_KINDS - 1);
                    state_next = (command == CMD_WITHDRAW) ? ST_DIV : ST_BAL;
                end
            end
            ST_DIV:
            begin
                state_next = ST_TAKE;
            end
            ST_TAKE:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_COMMIT:
            begin
                idx_next   = IDX_W'(NOTE_KINDS - 1);
                state_next = ST_BAL;
            end
            ST_BAL:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd         = '0;
        cmd.idx     = idx_reg;
        in_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_DIV:    cmd.div    = 1'b1;
            ST_TAKE:   cmd.take   = 1'b1;
            ST_COMMIT: cmd.commit = 1'b1;
            ST_BAL:    cmd.bal    = 1'b1;
            ST_FINISH: cmd.publish = stat.out_free;
            default:   cmd.idx    = idx_reg;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/ndg_datapath.sv
`default_nettype none

module ndg_datapath #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ndg_pkg::ndg_cmd_t            cmd,
    output ndg_pkg::ndg_stat_t                stat,
    input  wire logic                         command,
    input  wire logic [ndg_pkg::AMOUNT_W-1:0] amount,
    input  wire logic [ndg_pkg::LOAD_W-1:0]   load_fives,
    input  wire logic [ndg_pkg::LOAD_W-1:0]   load_tens,
    input  wire logic [ndg_pkg::LOAD_W-1:0]   load_twenties,
    input  wire logic [ndg_pkg::LOAD_W-1:0]   load_fifties,
    input  wire logic                         out_stall,
    output logic                              out_valid,
    output logic                              status,
    output logic [ndg_pkg::OUT_W-1:0]         out_fives,
    output logic [ndg_pkg::OUT_W-1:0]         out_tens,
    output logic [ndg_pkg::OUT_W-1:0]         out_twenties,
    output logic [ndg_pkg::OUT_W-1:0]         out_fifties,
    output logic [ndg_pkg::BAL_W-1:0]         balance,
    output logic [ndg_pkg::NOTE_W-1:0]        smallest_note
);
    import ndg_pkg::*;

    localparam int CMP_W  = (COUNT_WIDTH > WANT_W) ? COUNT_WIDTH : WANT_W;
    localparam int TERM_W = (COUNT_WIDTH + NOTE_W > BAL_W) ? COUNT_WIDTH + NOTE_W : BAL_W;

    logic [COUNT_WIDTH-1:0] stock_reg [NOTE_KINDS];
    logic [COUNT_WIDTH-1:0] stock_next [NOTE_KINDS];
    logic [COUNT_WIDTH-1:0] taken_reg [NOTE_KINDS];
    logic [COUNT_WIDTH-1:0] taken_next [NOTE_KINDS];
    logic [AMOUNT_W-1:0]    rest_reg;
    logic [AMOUNT_W-1:0]    rest_next;
    logic [WANT_W-1:0]      want_reg;
    logic [WANT_W-1:0]      want_next;
    logic [BAL_W-1:0]       acc_reg;
    logic [BAL_W-1:0]       acc_next;
    logic                   status_reg;
    logic                   status_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_status_reg;
    logic [OUT_W-1:0]       out_count_reg [NOTE_KINDS];
    logic [BAL_W-1:0]       out_balance_reg;
    logic [NOTE_W-1:0]      out_smallest_reg;

    logic [AMOUNT_W-1:0]    div_in;
    logic [PROD_W-1:0]      prod;
    logic [PROD_W-1:0]      prod_sh;
    logic [CMP_W-1:0]       want_ext;
    logic [CMP_W-1:0]       stock_ext;
    logic [CMP_W-1:0]       got;
    logic [CMP_W+NOTE_W-1:0] got_value;
    logic [TERM_W-1:0]      term;
    logic [NOTE_W-1:0]      smallest;

    assign stat.out_free = !out_valid_reg || !out_stall;

    // quotient by reciprocal multiplication
    always_comb
    begin
        div_in    = rest_reg >> PRE_SHIFT[cmd.idx];
        prod      = PROD_W'(div_in) * PROD_W'(RECIP[cmd.idx]);
        prod_sh   = prod >> POST_SHIFT[cmd.idx];
        want_next = prod_sh[WANT_W-1:0];
    end

    always_comb
    begin
        want_ext  = CMP_W'(want_reg);
        stock_ext = CMP_W'(stock_reg[cmd.idx]);
        got       = (want_ext < stock_ext) ? want_ext : stock_ext;
        got_value = (CMP_W + NOTE_W)'(got) * (CMP_W + NOTE_W)'(NOTE_VALUE[cmd.idx]);
        term      = TERM_W'(stock_reg[cmd.idx]) * TERM_W'(NOTE_VALUE[cmd.idx]);
    end

    always_comb
    begin
        smallest = NOTE_VALUE[NOTE_KINDS-1];
        for (int k = NOTE_KINDS - 1; k >= 0; k--)
        begin
            if (stock_reg[k] != '0)
            begin
                smallest = NOTE_VALUE[k];
            end
        end
    end

    always_comb
    begin
        stock_next  = stock_reg;
        taken_next  = taken_reg;
        rest_next   = rest_reg;
        acc_next    = acc_reg;
        status_next = status_reg;
        if (cmd.accept)
        begin
            rest_next   = amount;
            status_next = STATUS_DONE;
            for (int k = 0; k < NOTE_KINDS; k++)
            begin
                taken_next[k] = '0;
            end
            if (command == CMD_LOAD)
            begin
                stock_next[0] = COUNT_WIDTH'(load_fives);
                stock_next[1] = COUNT_WIDTH'(load_tens);
                stock_next[2] = COUNT_WIDTH'(load_twenties);
                stock_next[3] = COUNT_WIDTH'(load_fifties);
            end
        end
        if (cmd.take)
        begin
            taken_next[cmd.idx] = COUNT_WIDTH'(got);
            rest_next           = rest_reg - got_value[AMOUNT_W-1:0];
        end
        if (cmd.commit)
        begin
            if (rest_reg == '0)
            begin
                for (int k = 0; k < NOTE_KINDS; k++)
                begin
                    stock_next[k] = stock_reg[k] - taken_reg[k];
                end
            end
            else
            begin
                status_next = STATUS_IMPOSSIBLE;
                for (int k = 0; k < NOTE_KINDS; k++)
                begin
                    taken_next[k] = '0;
                end
            end
        end
        if (cmd.bal)
        begin
            if (cmd.idx == IDX_W'(NOTE_KINDS - 1))
            begin
                acc_next = term[BAL_W-1:0];
            end
            else
            begin
                acc_next = acc_reg + term[BAL_W-1:0];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NOTE_KINDS; k++)
            begin
                stock_reg[k] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            stock_reg     <= stock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        taken_reg  <= taken_next;
        rest_reg   <= rest_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        if (cmd.div)
        begin
            want_reg <= want_next;
        end
        if (cmd.publish)
        begin
            out_status_reg   <= status_reg;
            out_balance_reg  <= acc_reg;
            out_smallest_reg <= smallest;
            for (int k = 0; k < NOTE_KINDS; k++)
            begin
                out_count_reg[k] <= OUT_W'(taken_reg[k]);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign out_fives     = out_count_reg[0];
    assign out_tens      = out_count_reg[1];
    assign out_twenties  = out_count_reg[2];
    assign out_fifties   = out_count_reg[3];
    assign balance       = out_balance_reg;
    assign smallest_note = out_smallest_reg;

endmodule

`default_nettype wire

>>> rtl/note_dispenser_greedy.sv
// Note dispenser with stock counters for notes of 5, 10, 20 and 50.
// Input channel (in_valid / in_stall): command 0 loads the four stock counts
// from load_*; command 1 withdraws amount, taking from the largest note down
// as many notes as stock and remaining amount allow.
// Output channel (out_valid / out_stall): one result per input transaction:
// status (0 done, 1 impossible, stock unchanged), notes dispensed per value,
// balance left in stock and the smallest stocked note (50 when empty).
// The next transaction is taken only after the result of the last one has
// been published, so one transaction is worked on at a time. A withdrawal
// goes through one shared reciprocal multiplier and subtractor that handle
// the four note values in turn, largest first, then a commit step; both
// kinds then run a balance accumulator that adds one note value per cycle.
// in_stall is high while a transaction is being worked on.
// A finished result waits in the output register while out_stall is high; a
// new transaction may be accepted meanwhile, and its result is held back
// until the pending one is taken.
// Reset clears the stock counts and empties the output register.
`default_nettype none

module note_dispenser_greedy #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         command,
    input  wire logic [ndg_pkg::AMOUNT_W-1:0] amount,
    input  wire logic [ndg_pkg::LOAD_W-1:0]   load_fives,
    input  wire logic [ndg_pkg::LOAD_W-1:0]   load_tens,
    input  wire logic [ndg_pkg::LOAD_W-1:0]   load_twenties,
    input  wire logic [ndg_pkg::LOAD_W-1:0]   load_fifties,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              status,
    output logic [ndg_pkg::OUT_W-1:0]         out_fives,
    output logic [ndg_pkg::OUT_W-1:0]         out_tens,
    output logic [ndg_pkg::OUT_W-1:0]         out_twenties,
    output logic [ndg_pkg::OUT_W-1:0]         out_fifties,
    output logic [ndg_pkg::BAL_W-1:0]         balance,
    output logic [ndg_pkg::NOTE_W-1:0]        smallest_note
);
    import ndg_pkg::*;

    ndg_cmd_t  cmd;
    ndg_stat_t stat;

    ndg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    ndg_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .command       (command),
        .amount        (amount),
        .load_fives    (load_fives),
        .load_tens     (load_tens),
        .load_twenties (load_twenties),
        .load_fifties  (load_fifties),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .out_fives     (out_fives),
        .out_tens      (out_tens),
        .out_twenties  (out_twenties),
        .out_fifties   (out_fifties),
        .balance       (balance),
        .smallest_note (smallest_note)
    );

endmodule

`default_nettype wire

>>> rtl/ndg_checker.sv
`default_nettype none

module ndg_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic                         status,
    input wire logic [ndg_pkg::OUT_W-1:0]    out_fives,
    input wire logic [ndg_pkg::OUT_W-1:0]    out_tens,
    input wire logic [ndg_pkg::OUT_W-1:0]    out_twenties,
    input wire logic [ndg_pkg::OUT_W-1:0]    out_fifties,
    input wire logic [ndg_pkg::NOTE_W-1:0]   smallest_note
);
    import ndg_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("transaction accepted while previous one in progress");

    a_impossible_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_IMPOSSIBLE |->
            out_fives == '0 && out_tens == '0 && out_twenties == '0 && out_fifties == '0)
        else $error("notes reported on impossible withdrawal");

    a_smallest_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> smallest_note == NOTE_VALUE[0] || smallest_note == NOTE_VALUE[1] ||
            smallest_note == NOTE_VALUE[2] || smallest_note == NOTE_VALUE[3])
        else $error("smallest note is not a note value");

endmodule

bind note_dispenser_greedy ndg_checker u_checker (.*);

`default_nettype wire

>>> tb/tb_note_dispenser_greedy.sv
`timescale 1ns / 100ps

module tb_note_dispenser_greedy;

    import ndg_pkg::*;

    localparam int RANDOM_ITEMS   = 500;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 120;
    localparam int DRAIN_CYCLES   = 30;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                status;
        logic [OUT_W-1:0]    fives;
        logic [OUT_W-1:0]    tens;
        logic [OUT_W-1:0]    twenties;
        logic [OUT_W-1:0]    fifties;
        logic [BAL_W-1:0]    balance;
        logic [NOTE_W-1:0]   smallest;
    } payout_t;

    class payout_predictor;
        logic [LOAD_W-1:0] stock [NOTE_KINDS];
        payout_t           payouts_due [$];
        int                failures;
        int                checked;
        int                loads;
        int                withdrawals;
        int                refused;

        function new();
            for (int k = 0; k < NOTE_KINDS; k++)
            begin
                stock[k] = '0;
            end
            failures    = 0;
            checked     = 0;
            loads       = 0;
            withdrawals = 0;
            refused     = 0;
        endfunction

        function logic [BAL_W-1:0] stock_value();
            logic [BAL_W-1:0] sum;
            sum = '0;
            for (int k = 0; k < NOTE_KINDS; k++)
            begin
                sum = sum + BAL_W'(stock[k]) * BAL_W'(NOTE_VALUE[k]);
            end
            return sum;
        endfunction

        function void take_request(logic cmd, logic [AMOUNT_W-1:0] amt,
                                   logic [LOAD_W-1:0] c5, logic [LOAD_W-1:0] c10,
                                   logic [LOAD_W-1:0] c20, logic [LOAD_W-1:0] c50);
            payout_t             due;
            logic [LOAD_W-1:0]   taken [NOTE_KINDS];
            logic [AMOUNT_W-1:0] rest;
            logic [AMOUNT_W-1:0] want;
            due.status = STATUS_DONE;
            for (int k = 0; k < NOTE_KINDS; k++)
            begin
                taken[k] = '0;
            end
            if (cmd == CMD_LOAD)
            begin
                loads++;
                stock[0] = c5;
                stock[1] = c10;
                stock[2] = c20;
                stock[3] = c50;
            end
            else
            begin
                withdrawals++;
                rest = amt;
                for (int k = NOTE_KINDS - 1; k >= 0; k--)
                begin
                    want     = rest / AMOUNT_W'(NOTE_VALUE[k]);
                    taken[k] = (want < AMOUNT_W'(stock[k])) ? LOAD_W'(want) : stock[k];
                    rest     = rest - AMOUNT_W'(taken[k]) * AMOUNT_W'(NOTE_VALUE[k]);
                end
                if (rest == '0)
                begin
                    for (int k = 0; k < NOTE_KINDS; k++)
                    begin
                        stock[k] = stock[k] - taken[k];
                    end
                end
                else
                begin
                    refused++;
                    due.status = STATUS_IMPOSSIBLE;
                    for (int k = 0; k < NOTE_KINDS; k++)
                    begin
                        taken[k] = '0;
                    end
                end
            end
            due.fives    = taken[0];
            due.tens     = taken[1];
            due.twenties = taken[2];
            due.fifties  = taken[3];
            due.balance  = stock_value();
            due.smallest = NOTE_VALUE[NOTE_KINDS-1];
            for (int k = NOTE_KINDS - 1; k >= 0; k--)
            begin
                if (stock[k] != '0)
                begin
                    due.smallest = NOTE_VALUE[k];
                end
            end
            payouts_due.push_back(due);
        endfunction

        function string show(payout_t p);
            return $sformatf("status=%0d n5=%0d n10=%0d n20=%0d n50=%0d balance=%0d smallest=%0d",
                             p.status, p.fives, p.tens, p.twenties, p.fifties,
                             p.balance, p.smallest);
        endfunction

        function void check_payout(payout_t got);
            payout_t due;
            if (payouts_due.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: result with no transaction outstanding: %s", show(got));
                return;
            end
            due = payouts_due.pop_front();
            if (got.status !== due.status || got.fives !== due.fives ||
                got.tens !== due.tens || got.twenties !== due.twenties ||
                got.fifties !== due.fifties || got.balance !== due.balance ||
                got.smallest !== due.smallest)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("ERROR: result %0d mismatch", checked);
                    $display("    expected %s", show(due));
                    $display("    actual   %s", show(got));
                end
            end
            checked++;
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [AMOUNT_W-1:0] amount;
    logic [LOAD_W-1:0]   load_fives;
    logic [LOAD_W-1:0]   load_tens;
    logic [LOAD_W-1:0]   load_twenties;
    logic [LOAD_W-1:0]   load_fifties;
    logic                out_valid;
    logic                out_stall;
    logic                status;
    logic [OUT_W-1:0]    out_fives;
    logic [OUT_W-1:0]    out_tens;
    logic [OUT_W-1:0]    out_twenties;
    logic [OUT_W-1:0]    out_fifties;
    logic [BAL_W-1:0]    balance;
    logic [NOTE_W-1:0]   smallest_note;

    payout_predictor predictor = new();
    bit              calm = 1'b0;
    int              results_seen = 0;
    bit              hold_done = 1'b0;

    note_dispenser_greedy dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .amount        (amount),
        .load_fives    (load_fives),
        .load_tens     (load_tens),
        .load_twenties (load_twenties),
        .load_fifties  (load_fifties),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_fives     (out_fives),
        .out_tens      (out_tens),
        .out_twenties  (out_twenties),
        .out_fifties   (out_fifties),
        .balance       (balance),
        .smallest_note (smallest_note)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(input logic cmd, input logic [AMOUNT_W-1:0] amt,
                             input logic [LOAD_W-1:0] c5, input logic [LOAD_W-1:0] c10,
                             input logic [LOAD_W-1:0] c20, input logic [LOAD_W-1:0] c50);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!calm)
        begin
            if (r >= 96)
                gap = $urandom_range(12, 50);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        amount        <= amt;
        load_fives    <= c5;
        load_tens     <= c10;
        load_twenties <= c20;
        load_fifties  <= c50;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predictor.take_request(cmd, amt, c5, c10, c20, c50);
    endtask

    task automatic load_stock(input logic [LOAD_W-1:0] c5, input logic [LOAD_W-1:0] c10,
                              input logic [LOAD_W-1:0] c20, input logic [LOAD_W-1:0] c50);
        send_item(CMD_LOAD, AMOUNT_W'($urandom), c5, c10, c20, c50);
    endtask

    task automatic withdraw(input logic [AMOUNT_W-1:0] amt);
        send_item(CMD_WITHDRAW, amt, LOAD_W'($urandom), LOAD_W'($urandom),
                  LOAD_W'($urandom), LOAD_W'($urandom));
    endtask

    function automatic logic [LOAD_W-1:0] rand_count(int mode);
        if (mode == 0)
            return ($urandom_range(0, 3) == 0) ? '0 : LOAD_W'($urandom_range(1, 30));
        else if (mode == 1)
            return LOAD_W'($urandom);
        else
            return LOAD_W'($urandom_range(0, 3));
    endfunction

    initial
    begin
        int               r;
        int               mode;
        logic [BAL_W-1:0] bal;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        command       <= CMD_LOAD;
        amount        <= '0;
        load_fives    <= '0;
        load_tens     <= '0;
        load_twenties <= '0;
        load_fifties  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        withdraw('0);
        withdraw(AMOUNT_W'(5));
        load_stock('1, '1, '1, '1);
        withdraw('1);
        withdraw(predictor.stock_value());
        withdraw(AMOUNT_W'(5));
        load_stock('0, '0, LOAD_W'(3), LOAD_W'(1));
        withdraw(AMOUNT_W'(60));
        withdraw(AMOUNT_W'(70));
        withdraw(AMOUNT_W'(3));
        withdraw('0);
        load_stock(LOAD_W'(1), '0, '0, '0);
        load_stock('0, LOAD_W'(1), '0, '0);
        load_stock('0, '0, LOAD_W'(1), '0);
        load_stock('0, '0, '0, LOAD_W'(1));
        load_stock(LOAD_W'(100), LOAD_W'(100), LOAD_W'(100), LOAD_W'(100));
        withdraw(AMOUNT_W'(85));
        withdraw(AMOUNT_W'(8385));
        load_stock(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        withdraw(23'h2AAAAA);
        withdraw(23'h555555);
        load_stock(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        withdraw(23'h555555);
        load_stock('0, '0, '0, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 200 && i < 260);
            r    = $urandom_range(0, 99);
            bal  = predictor.stock_value();
            if (r < 20)
            begin
                mode = $urandom_range(0, 2);
                load_stock(rand_count(mode), rand_count(mode), rand_count(mode),
                           rand_count(mode));
            end
            else if (r < 52)
                withdraw(AMOUNT_W'(5 * $urandom_range(0, int'(bal) / 5)));
            else if (r < 68)
                withdraw(AMOUNT_W'(5 * $urandom_range(0, 40)));
            else if (r < 76)
                withdraw(bal);
            else if (r < 86)
                withdraw(AMOUNT_W'($urandom_range(0, int'(bal) + 100)));
            else if (r < 95)
                withdraw(AMOUNT_W'($urandom));
            else
                withdraw(($urandom_range(0, 1) == 0) ? '0 : '1);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (predictor.payouts_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d loads and %0d withdrawals, %0d refused as impossible",
                 predictor.loads, predictor.withdrawals, predictor.refused);
        $display("Checked %0d results, %0d mismatches", predictor.checked, predictor.failures);
        if (predictor.failures == 0 && predictor.payouts_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int r;
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                predictor.check_payout('{status, out_fives, out_tens, out_twenties,
                                         out_fifties, balance, smallest_note});
                results_seen++;
            end
            // hold the output for a long stretch so the block backs up
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm)
            begin
                r = $urandom_range(0, 99);
                if (r >= 98)
                    stall_left = $urandom_range(15, 40);
                else if (r >= 92)
                    stall_left = $urandom_range(4, 10);
                else if (r >= 70)
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, predictor.payouts_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
